### design/swdh_pkg.sv
// Package for the SWD host transfer engine: phase and status codes, the item,
// configuration and result structs, and the phase sequencing functions.
// Depends on nothing; every other design file imports it.
package swdh_pkg;

  typedef enum logic [11:0] {
    PH_IDLE  = 12'b0000_0000_0001,
    PH_REQ   = 12'b0000_0000_0010,
    PH_TRN1  = 12'b0000_0000_0100,
    PH_ACK   = 12'b0000_0000_1000,
    PH_RDATA = 12'b0000_0001_0000,
    PH_TRN_R = 12'b0000_0010_0000,
    PH_TRN_W = 12'b0000_0100_0000,
    PH_WDATA = 12'b0000_1000_0000,
    PH_DUMR  = 12'b0001_0000_0000,
    PH_TRN_F = 12'b0010_0000_0000,
    PH_DUMW  = 12'b0100_0000_0000,
    PH_PERR  = 12'b1000_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_WAIT   = 3'd1,
    ST_FAULT  = 3'd2,
    ST_PROTO  = 3'd3,
    ST_PARITY = 3'd4
  } status_t;

  typedef enum logic {
    CFG_TURNAROUND = 1'b0,
    CFG_DATA_PHASE = 1'b1
  } cfg_index_t;

  localparam logic       CMD_START  = 1'b0;
  localparam logic [2:0] ACK_OK     = 3'b001;
  localparam logic [2:0] ACK_WAIT   = 3'b010;
  localparam logic [2:0] ACK_FAULT  = 3'b100;
  localparam logic [7:0] REQ_FRAME  = 8'h81;
  localparam logic [5:0] REQ_BITS   = 6'd8;
  localparam logic [5:0] ACK_BITS   = 6'd3;
  localparam logic [5:0] DATA_BITS  = 6'd33;
  localparam logic [2:0] TRN_RESET  = 3'd1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  request_bits;
    logic [31:0] write_word;
    logic        line_in;
  } item_t;

  typedef struct packed {
    logic [2:0] turnaround_cycles;
    logic       data_phase_on_wait;
  } cfg_t;

  typedef struct packed {
    logic        line_out;
    logic        line_drive;
    logic        clock_pulse;
    logic        transfer_done;
    logic        busy_res;
    logic [2:0]  ack_raw;
    logic [2:0]  status;
    logic [31:0] read_word;
  } result_t;

  function automatic logic [5:0] phase_len(phase_t p, logic [2:0] trn);
    logic [5:0] len;
    unique case (p)
      PH_REQ:                               len = REQ_BITS;
      PH_ACK:                               len = ACK_BITS;
      PH_TRN1, PH_TRN_R, PH_TRN_W, PH_TRN_F: len = {3'b000, trn};
      PH_PERR:                              len = DATA_BITS + {3'b000, trn};
      PH_RDATA, PH_WDATA, PH_DUMR, PH_DUMW: len = DATA_BITS;
      default:                              len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic phase_t phase_after(phase_t p, logic [2:0] ack, logic rd, logic dp);
    phase_t nxt;
    unique case (p)
      PH_REQ:   nxt = PH_TRN1;
      PH_TRN1:  nxt = PH_ACK;
      PH_ACK: begin
        if (ack == ACK_OK) begin
          nxt = rd ? PH_RDATA : PH_TRN_W;
        end else if (ack == ACK_WAIT || ack == ACK_FAULT) begin
          nxt = (dp && rd) ? PH_DUMR : PH_TRN_F;
        end else begin
          nxt = PH_PERR;
        end
      end
      PH_RDATA: nxt = PH_TRN_R;
      PH_TRN_W: nxt = PH_WDATA;
      PH_DUMR:  nxt = PH_TRN_F;
      PH_TRN_F: nxt = (dp && !rd) ? PH_DUMW : PH_IDLE;
      default:  nxt = PH_IDLE;
    endcase
    return nxt;
  endfunction

endpackage

### design/swdh_in_stage.sv
// Input register of the SWD host transfer engine: holds one accepted item
// until the engine steps on it. Depends on swdh_pkg.
module swdh_in_stage
  import swdh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  logic  valid;
  item_t item;

  assign in_ready   = !valid || take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### design/swdh_engine.sv
// Transfer state of the SWD host transfer engine and the logic that advances
// it by one item: request, turnaround, ack and data phases. Depends on swdh_pkg.
module swdh_engine
  import swdh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t      phase, phase_next, hop;
  logic [5:0]  bit_count, bit_count_next, count_inc;
  logic [32:0] shift_word, shift_word_next;
  logic [3:0]  held_request, held_request_next;
  logic [31:0] held_write_word, held_write_word_next;
  logic [2:0]  held_ack, held_ack_next;
  logic        parity_acc, parity_acc_next;
  logic        rd;
  logic [7:0]  req_byte;

  assign rd       = held_request[1];
  assign req_byte = REQ_FRAME | {2'b00, ^held_request, held_request, 1'b0};

  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    shift_word_next      = shift_word;
    held_request_next    = held_request;
    held_write_word_next = held_write_word;
    held_ack_next        = held_ack;
    parity_acc_next      = parity_acc;
    count_inc            = bit_count + 6'd1;
    hop                  = PH_IDLE;
    res                  = '0;
    if (item.cmd == CMD_START) begin
      if (phase == PH_IDLE) begin
        held_request_next    = item.request_bits;
        held_write_word_next = item.write_word;
        held_ack_next        = 3'd0;
        shift_word_next      = 33'd0;
        bit_count_next       = 6'd0;
        parity_acc_next      = item.request_bits[1] ? 1'b0 : ^item.write_word;
        phase_next           = PH_REQ;
      end
    end else if (phase != PH_IDLE) begin
      res.clock_pulse = 1'b1;
      unique case (phase)
        PH_REQ: begin
          res.line_drive = 1'b1;
          res.line_out   = req_byte[bit_count[2:0]];
        end
        PH_ACK: begin
          if (bit_count < ACK_BITS) begin
            held_ack_next = held_ack | ({2'b00, item.line_in} << bit_count[1:0]);
          end
        end
        PH_RDATA: begin
          shift_word_next = {item.line_in, shift_word[32:1]};
          if (!bit_count[5]) begin
            parity_acc_next = parity_acc ^ item.line_in;
          end
        end
        PH_WDATA: begin
          res.line_drive = 1'b1;
          res.line_out   = bit_count[5] ? parity_acc : held_write_word[bit_count[4:0]];
        end
        PH_DUMW: begin
          res.line_drive = 1'b1;
        end
        default: begin
        end
      endcase
      bit_count_next = count_inc;
      if (count_inc >= phase_len(phase, cfg.turnaround_cycles)) begin
        hop = phase_after(phase, held_ack_next, rd, cfg.data_phase_on_wait);
        if (hop != PH_IDLE && phase_len(hop, cfg.turnaround_cycles) == 6'd0) begin
          hop = phase_after(hop, held_ack_next, rd, cfg.data_phase_on_wait);
        end
        phase_next     = hop;
        bit_count_next = 6'd0;
        if (hop == PH_IDLE) begin
          res.transfer_done = 1'b1;
          if (held_ack_next == ACK_OK) begin
            if (rd) begin
              if (shift_word_next[32] ^ parity_acc_next) begin
                res.status = ST_PARITY;
              end else begin
                res.read_word = shift_word_next[31:0];
              end
            end
          end else if (held_ack_next == ACK_WAIT) begin
            res.status = ST_WAIT;
          end else if (held_ack_next == ACK_FAULT) begin
            res.status = ST_FAULT;
          end else begin
            res.status = ST_PROTO;
          end
        end
      end
    end
    res.busy_res = (phase_next != PH_IDLE);
    res.ack_raw  = held_ack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= 6'd0;
      shift_word      <= 33'd0;
      held_request    <= 4'd0;
      held_write_word <= 32'd0;
      held_ack        <= 3'd0;
      parity_acc      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      shift_word      <= shift_word_next;
      held_request    <= held_request_next;
      held_write_word <= held_write_word_next;
      held_ack        <= held_ack_next;
      parity_acc      <= parity_acc_next;
    end
  end

endmodule

### design/swdh_out_stage.sv
// Result register of the SWD host transfer engine: holds one result until the
// receiver takes it. Depends on swdh_pkg.
module swdh_out_stage
  import swdh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    free,
  output result_t out_res
);

  logic    valid;
  result_t res;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

### design/swd_host_transfer_engine.sv
// Top level of the SWD host transfer engine: configuration registers, input
// register, transfer engine and result register.
// Depends on swdh_pkg, swdh_in_stage, swdh_engine and swdh_out_stage.
//
// Each input transaction is either a start (cmd 0), which latches the request
// nibble and the write word when no transfer is running, or a tick (cmd 1),
// which stands for one SWCLK bit period and carries the sampled SWDIO level.
// Every input transaction gives exactly one output transaction with the SWDIO
// level and drive enable for that period, a clock pulse flag, the done flag,
// the busy flag, the ack bits and, on the done period, status and read word.
// An item enters the input register, is stepped through the transfer state and
// lands in the result register, one transaction per cycle sustained while the
// receiver does not stall; the state update between the two registers is
// combinational.
// When the receiver stalls, the result register holds its transaction and the
// input register holds one more; in_ready falls only when both are full.
// Reset empties both registers, returns the transfer to idle, sets the turnaround
// to one period and the dummy data phase off. Configuration writes take effect at
// once; the user must make them while no transfer is in flight (not enforced).
module swd_host_transfer_engine
  import swdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [3:0]  request_bits,
  input  logic [31:0] write_word,
  input  logic        line_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        line_out,
  output logic        line_drive,
  output logic        clock_pulse,
  output logic        transfer_done,
  output logic        busy_res,
  output logic [2:0]  ack_raw,
  output logic [2:0]  status,
  output logic [31:0] read_word
);

  cfg_t    cfg;
  item_t   in_item, held_item;
  result_t step_res, out_res;
  logic    held_valid, out_free, take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turnaround_cycles  <= TRN_RESET;
      cfg.data_phase_on_wait <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TURNAROUND: cfg.turnaround_cycles  <= cfg_data;
        CFG_DATA_PHASE: cfg.data_phase_on_wait <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_item = '{cmd: cmd, request_bits: request_bits, write_word: write_word,
                     line_in: line_in};
  assign take    = held_valid && out_free;

  swdh_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  swdh_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (held_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  swdh_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_res  (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .free      (out_free),
    .out_res   (out_res)
  );

  assign line_out      = out_res.line_out;
  assign line_drive    = out_res.line_drive;
  assign clock_pulse   = out_res.clock_pulse;
  assign transfer_done = out_res.transfer_done;
  assign busy_res      = out_res.busy_res;
  assign ack_raw       = out_res.ack_raw;
  assign status        = out_res.status;
  assign read_word     = out_res.read_word;

endmodule

### design/swdh_checker.sv
// Port checker for the SWD host transfer engine and the bind that attaches it.
// Depends on swdh_pkg and the swd_host_transfer_engine port list.
module swdh_checker
  import swdh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        line_out,
  input logic        line_drive,
  input logic        clock_pulse,
  input logic        transfer_done,
  input logic        busy_res,
  input logic [2:0]  status,
  input logic [31:0] read_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_word)
      && $stable(line_out) && $stable(transfer_done))
    else $error("output transaction changed while stalled");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && transfer_done |-> !busy_res && clock_pulse)
    else $error("done period still busy or without clock");

  a_no_clock_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !clock_pulse |-> !line_drive && !line_out && !transfer_done)
    else $error("line activity without a clock period");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK || read_word != 32'd0) |-> transfer_done)
    else $error("status or read word outside the done period");

  a_undriven_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_drive |-> !line_out)
    else $error("line level set while not driving");

endmodule

bind swd_host_transfer_engine swdh_checker u_swdh_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .line_out      (line_out),
  .line_drive    (line_drive),
  .clock_pulse   (clock_pulse),
  .transfer_done (transfer_done),
  .busy_res      (busy_res),
  .status        (status),
  .read_word     (read_word)
);
